FILE: design/eabf_pkg.sv
// ----------------------------------------------------------------------------
// eabf_pkg: shared types and constants for the 3x3 neighbourhood mean filter
// Holds controller state codes, command/status structs and field widths.
// ----------------------------------------------------------------------------
package eabf_pkg;

  localparam int unsigned CfgIdxBits = 1;
  localparam logic [CfgIdxBits-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CfgIdxBits-1:0] CFG_HEIGHT = 1'b1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  localparam int unsigned SumBits  = 12;
  localparam int unsigned MeanBits = 16;
  localparam int unsigned CntBits  = 4;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_SUM   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, issue store read
    logic shift;     // write stores, shift window
    logic sum;       // form masked sum and count
    logic div_start;
    logic div_step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emits;     // this request produces a result
    logic is_nop;    // early drain, nothing to do
    logic div_done;
  } dp_sts_t;

endpackage

FILE: design/eabf_datapath.sv
// ----------------------------------------------------------------------------
// eabf_datapath: line stores, window, position counters and mean divider
// Two row memories, a 3x3 window, frame counters and a restoring divider.
// ----------------------------------------------------------------------------
module eabf_datapath
  import eabf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_HEIGHT  = 4096,
  parameter int unsigned SAMPLE_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CfgIdxBits-1:0]  cfg_idx,
  input  logic [31:0]            cfg_wdata,
  input  logic                   in_cmd,
  input  logic [SAMPLE_BITS-1:0] in_height_sample,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  output logic [MeanBits-1:0]    mean,
  output logic [CntBits-1:0]     count,
  output logic                   last
);

  localparam int unsigned AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WB  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HB  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RB  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned NB  = WB + HB;
  localparam int unsigned QB  = SumBits + 8;

  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [WB-1:0] w_eff;
  logic [HB-1:0] h_eff;
  logic [NB-1:0] total;

  logic [NB-1:0] n_r;
  logic [AW-1:0] col_r;
  logic [RB-1:0] orow_r;
  logic [AW-1:0] ocol_r;

  logic [7:0] older_mem [MAX_WIDTH];
  logic [7:0] newer_mem [MAX_WIDTH];
  logic [7:0] top_r, mid_r, val_r;
  logic [7:0] win_r [9];
  logic       cmd_r;

  logic [SumBits-1:0] sum_r;
  logic [CntBits-1:0] cnt_r;
  logic               last_r;
  logic [QB-1:0]      rem_r;
  logic [QB-1:0]      quo_r;
  logic [4:0]         step_r;

  always_comb begin
    if (width_r == '0) w_eff = WB'(1);
    else if ({21'd0, width_r} > 32'(MAX_WIDTH)) w_eff = WB'(MAX_WIDTH);
    else w_eff = WB'(width_r);
    if (height_r == '0) h_eff = HB'(1);
    else if ({19'd0, height_r} > 32'(MAX_HEIGHT)) h_eff = HB'(MAX_HEIGHT);
    else h_eff = HB'(height_r);
  end

  assign total = NB'(w_eff) * NB'(h_eff);

  // current request classification, valid while in_valid holds
  logic full;
  assign full       = (n_r >= total);
  assign sts.is_nop = (in_cmd == CMD_DRAIN) && !full;
  assign sts.emits  = (n_r >= NB'(w_eff) + NB'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      top_r <= older_mem[col_r];
      mid_r <= newer_mem[col_r];
      val_r <= full ? 8'd0 : in_height_sample[7:0];
    end
    if (cmd.shift) begin
      older_mem[col_r] <= mid_r;
      newer_mem[col_r] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]   <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= top_r;
      win_r[5] <= mid_r;
      win_r[8] <= val_r;
    end
  end

  logic row_ok [3];
  logic col_ok [3];
  always_comb begin
    row_ok[0] = (orow_r != '0);
    row_ok[1] = 1'b1;
    row_ok[2] = (HB'(orow_r) + HB'(1) < h_eff);
    col_ok[0] = (ocol_r != '0);
    col_ok[1] = 1'b1;
    col_ok[2] = (WB'(ocol_r) + WB'(1) < w_eff);
  end

  logic [SumBits-1:0] sum_c;
  logic [CntBits-1:0] cnt_c;
  always_comb begin
    sum_c = '0;
    cnt_c = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          sum_c = sum_c + SumBits'(win_r[r*3+c]);
          cnt_c = cnt_c + CntBits'(1);
        end
      end
    end
  end

  logic last_c;
  assign last_c = (HB'(orow_r) + HB'(1) >= h_eff) && (WB'(ocol_r) + WB'(1) >= w_eff);

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      height_r <= 13'd1024;
      n_r      <= '0;
      col_r    <= '0;
      orow_r   <= '0;
      ocol_r   <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_WIDTH) width_r <= cfg_wdata[10:0];
      else height_r <= cfg_wdata[12:0];
      n_r    <= '0;
      col_r  <= '0;
      orow_r <= '0;
      ocol_r <= '0;
    end else begin
      if (cmd.shift) begin
        n_r <= n_r + NB'(1);
        if (WB'(col_r) + WB'(1) >= w_eff) col_r <= '0;
        else col_r <= col_r + AW'(1);
      end
      if (cmd.sum) begin
        if (last_c) begin
          n_r    <= '0;
          col_r  <= '0;
          orow_r <= '0;
          ocol_r <= '0;
        end else if (WB'(ocol_r) + WB'(1) >= w_eff) begin
          ocol_r <= '0;
          orow_r <= orow_r + RB'(1);
        end else begin
          ocol_r <= ocol_r + AW'(1);
        end
      end
    end
  end

  // restoring divider, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sum_r  <= sum_c;
      cnt_r  <= cnt_c;
      last_r <= last_c;
    end
    if (cmd.div_start) begin
      rem_r  <= '0;
      quo_r  <= {sum_r, 8'd0};
      step_r <= 5'(QB);
    end else if (cmd.div_step && step_r != '0) begin
      logic [QB-1:0] t;
      t = {rem_r[QB-2:0], quo_r[QB-1]};
      if (t >= QB'(cnt_r)) begin
        rem_r <= t - QB'(cnt_r);
        quo_r <= {quo_r[QB-2:0], 1'b1};
      end else begin
        rem_r <= t;
        quo_r <= {quo_r[QB-2:0], 1'b0};
      end
      step_r <= step_r - 5'd1;
    end
  end

  assign sts.div_done = (step_r == '0);
  assign mean  = (quo_r > QB'(16'hFFFF)) ? 16'hFFFF : quo_r[MeanBits-1:0];
  assign count = cnt_r;
  assign last  = last_r;

  logic unused;
  assign unused = cmd_r ^ ^in_height_sample ^ ^cfg_wdata;
  always_ff @(posedge clk) cmd_r <= in_cmd;

endmodule

FILE: design/eabf_ctrl.sv
// ----------------------------------------------------------------------------
// eabf_ctrl: sequencer for one request at a time
// Steps load, window shift, sum, divide and result hand-off.
// ----------------------------------------------------------------------------
module eabf_ctrl
  import eabf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    res_load,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state_r, state_nxt;
  logic   emit_r, emit_nxt;
  logic   ov_r, ov_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    emit_nxt  = emit_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    res_load  = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !sts.is_nop) begin
          cmd.load  = 1'b1;
          emit_nxt  = sts.emits;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.shift = 1'b1;
        state_nxt = emit_r ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        cmd.div_step = 1'b1;
        // hold the finished mean until the result register is free
        if (sts.div_done && (!ov_r || out_ready)) begin
          cmd.div_step = 1'b0;
          res_load     = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      emit_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

FILE: design/edge_aware_box_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// edge_aware_box_filter_3x3_unit: streaming 3x3 neighbourhood mean
// Raster height samples in, masked 3x3 mean in unsigned 8.8 out.
// ----------------------------------------------------------------------------
// channel | direction | fields
// in_     | input     | cmd, height_sample
// out_    | output    | smoothed_height, window_count, frame_last
// cfg_    | input     | index 0 width_in_use, index 1 height_in_use
//
// A result-less request only loads and shifts; one with a result also sums and
// runs the 20-step restoring divider. Early drains are taken while idle.
// Reset is synchronous; row stores are not cleared. A stalled result holds in
// the output register while the next request is accepted and worked.
module edge_aware_box_filter_3x3_unit
  import eabf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_HEIGHT  = 4096,
  parameter int unsigned SAMPLE_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_cmd,
  input  logic [SAMPLE_BITS-1:0] in_height_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [15:0]            out_smoothed_height,
  output logic [3:0]             out_window_count,
  output logic                   out_frame_last
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    res_load;
  logic [MeanBits-1:0] mean;
  logic [CntBits-1:0]  count;
  logic                last;

  assign cfg_ready = 1'b1;

  eabf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .res_load, .cmd, .sts
  );

  eabf_datapath #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk, .rst_n,
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_wdata(cfg_data),
    .in_cmd, .in_height_sample, .cmd, .sts, .mean, .count, .last
  );

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_smoothed_height <= mean;
      out_window_count    <= count;
      out_frame_last      <= last;
    end
  end

endmodule

FILE: design/eabf_checker.sv
// ----------------------------------------------------------------------------
// eabf_checker: port-level checks for the filter
// Watches handshakes and result fields on the top level.
// ----------------------------------------------------------------------------
module eabf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_smoothed_height,
  input logic [3:0]  out_window_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_smoothed_height))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_window_count != 4'd0 && out_window_count <= 4'd9)
    else $error("window count out of range");

  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_smoothed_height <= 16'hFF00)
    else $error("mean above sample range");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind edge_aware_box_filter_3x3_unit eabf_checker u_eabf_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready,
  .out_smoothed_height, .out_window_count
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: bench for the streaming 3x3 neighbourhood mean filter
// Drives raster frames of height samples and drain requests with random
// gaps on both channels. Every accepted request runs through a local model
// of the line stores and window; each result is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import eabf_pkg::*;

  typedef struct packed {
    logic [15:0] mean;
    logic [3:0]  cnt;
    logic        last;
  } mean_res_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        idx;
    logic [31:0] data;
    logic        cmd;
    logic        chk;
    mean_res_t   res;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [7:0]  in_height_sample;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_smoothed_height;
  logic [3:0]  out_window_count;
  logic        out_frame_last;

  edge_aware_box_filter_3x3_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_height_sample    (in_height_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_smoothed_height (out_smoothed_height),
    .out_window_count    (out_window_count),
    .out_frame_last      (out_frame_last)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #60000000;
    $display("status: fail");
    $finish;
  end

  // filter model state
  logic [7:0]  older_row [1024];
  logic [7:0]  newer_row [1024];
  logic [7:0]  win [9];
  int unsigned row_width;
  int unsigned row_count;
  int unsigned taken;
  int unsigned ocol;
  int unsigned orow;

  mean_res_t   pending_means [$];
  int          mismatches;
  int          items_sent;
  bit          ignored;
  bit          idle_off;
  bit          hold_req;

  function automatic int unsigned eff_width();
    if (row_width < 1) return 1;
    if (row_width > 1024) return 1024;
    return row_width;
  endfunction

  function automatic int unsigned eff_height();
    if (row_count < 1) return 1;
    if (row_count > 4096) return 4096;
    return row_count;
  endfunction

  function automatic void restart_frame();
    taken = 0;
    ocol = 0;
    orow = 0;
  endfunction

  function automatic bit filter_step(input logic cmd, input logic [7:0] s,
                                     output mean_res_t r);
    int unsigned w, h, tot, n, col, sum, cnt;
    int          rr, cc;
    logic [7:0]  top, mid, v;
    w = eff_width();
    h = eff_height();
    tot = w * h;
    n = taken;
    r = '0;
    ignored = (cmd == CMD_DRAIN) && (n < tot);
    if (ignored) return 0;
    v = (n < tot) ? s : 8'd0;
    col = n % w;
    top = older_row[col];
    mid = newer_row[col];
    older_row[col] = mid;
    newer_row[col] = v;
    for (int d = 0; d < 3; d++) begin
      win[d*3] = win[d*3+1];
      win[d*3+1] = win[d*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = v;
    taken = n + 1;
    if (n < w + 1) return 0;
    sum = 0;
    cnt = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      rr = int'(orow) + dr;
      if (rr < 0 || rr >= int'(h)) continue;
      for (int dc = -1; dc <= 1; dc++) begin
        cc = int'(ocol) + dc;
        if (cc < 0 || cc >= int'(w)) continue;
        sum += win[(dr+1)*3 + dc + 1];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    r.mean = 16'((sum * 256) / cnt);
    r.cnt = 4'(cnt);
    r.last = (orow >= h - 1) && (ocol >= w - 1);
    if (r.last) begin
      restart_frame();
    end else if (ocol + 1 >= w) begin
      ocol = 0;
      orow = (orow + 1) & 12'hFFF;
    end else begin
      ocol = (ocol + 1) & 10'h3FF;
    end
    return 1;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic send_item(input logic cmd, input logic [7:0] s,
                           output bit has, output mean_res_t r);
    int gap;
    gap = idle_off ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_height_sample <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
    has = filter_step(cmd, s, r);
    if (has) pending_means.insert(pending_means.size(), r);
    if (!ignored) items_sent++;
  endtask

  // drop valid, wait for every result, then let in-flight work settle
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_WIDTH) row_width = data & 32'h7FF;
    else row_count = data & 32'h1FFF;
    restart_frame();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one frame (or its first part_len requests) with early-drain noise
  task automatic run_frame(input int unsigned wv, input int unsigned hv,
                           input int part_len, input int pressure);
    int unsigned tot, len;
    logic [7:0]  s;
    logic        c;
    bit          has;
    mean_res_t   r;
    settle();
    write_reg(CFG_WIDTH, ($urandom & ~32'h7FF) | wv);
    write_reg(CFG_HEIGHT, ($urandom & ~32'h1FFF) | hv);
    tot = eff_width() * eff_height();
    len = (part_len > 0) ? part_len : tot + eff_width() + 1;
    idle_off = ($urandom_range(0, 4) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if (i == len / 2 && pressure == 1) hold_req = 1'b1;
      if (i == len / 2 && pressure == 2) begin
        settle();
      end
      case ($urandom_range(0, 3))
        0: s = 8'hFF;
        1: s = 8'h00;
        default: s = 8'($urandom);
      endcase
      if (i < tot && $urandom_range(0, 24) == 0)
        send_item(CMD_DRAIN, 8'($urandom), has, r);
      c = (i < tot) ? CMD_SAMPLE : 1'($urandom);
      send_item(c, s, has, r);
    end
  endtask

  step_row_t directed_rows [0:21] = '{
    '{ROW_CFG,  CFG_WIDTH,  32'd1, CMD_SAMPLE, 1'b0, '0},
    '{ROW_CFG,  CFG_HEIGHT, 32'd1, CMD_SAMPLE, 1'b0, '0},
    '{ROW_ITEM, 1'b0, 32'h5A, CMD_DRAIN,  1'b0, '0},
    '{ROW_ITEM, 1'b0, 32'hFF, CMD_SAMPLE, 1'b0, '0},
    '{ROW_ITEM, 1'b0, 32'h00, CMD_DRAIN,  1'b0, '0},
    '{ROW_ITEM, 1'b0, 32'h00, CMD_DRAIN,  1'b1, '{16'hFF00, 4'd1, 1'b1}},
    '{ROW_ITEM, 1'b0, 32'h00, CMD_SAMPLE, 1'b0, '0},
    '{ROW_ITEM, 1'b0, 32'h00, CMD_DRAIN,  1'b0, '0},
    '{ROW_ITEM, 1'b0, 32'h00, CMD_DRAIN,  1'b1, '{16'h0000, 4'd1, 1'b1}},
    // samples after frame end act as drains
    '{ROW_ITEM, 1'b0, 32'h80, CMD_SAMPLE, 1'b0, '0},
    '{ROW_ITEM, 1'b0, 32'hAA, CMD_SAMPLE, 1'b0, '0},
    '{ROW_ITEM, 1'b0, 32'h55, CMD_SAMPLE, 1'b1, '{16'h8000, 4'd1, 1'b1}},
    '{ROW_CFG,  CFG_WIDTH,  32'hFFFF_F803, CMD_SAMPLE, 1'b0, '0},
    '{ROW_CFG,  CFG_HEIGHT, 32'hFFFF_E003, CMD_SAMPLE, 1'b0, '0},
    '{ROW_ITEM, 1'b0, 32'hFF, CMD_SAMPLE, 1'b0, '0},
    '{ROW_ITEM, 1'b0, 32'hFF, CMD_SAMPLE, 1'b0, '0},
    '{ROW_ITEM, 1'b0, 32'hFF, CMD_SAMPLE, 1'b0, '0},
    '{ROW_ITEM, 1'b0, 32'hFF, CMD_SAMPLE, 1'b0, '0},
    '{ROW_ITEM, 1'b0, 32'hFF, CMD_SAMPLE, 1'b1, '{16'hFF00, 4'd4, 1'b0}},
    '{ROW_ITEM, 1'b0, 32'hFF, CMD_SAMPLE, 1'b1, '{16'hFF00, 4'd6, 1'b0}},
    '{ROW_ITEM, 1'b0, 32'hFF, CMD_SAMPLE, 1'b1, '{16'hFF00, 4'd4, 1'b0}},
    '{ROW_ITEM, 1'b0, 32'hFF, CMD_SAMPLE, 1'b1, '{16'hFF00, 4'd6, 1'b0}}
  };

  // result side: random stalls, one long hold-off on request
  initial begin
    int        stall;
    mean_res_t want;
    forever begin
      stall = idle_off ? 0 : $urandom_range(0, 6);
      if (hold_req) begin
        stall = 300;
        hold_req = 1'b0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_means.size() == 0) begin
        note_mismatch("result with no request waiting");
      end else begin
        want = pending_means.pop_front();
        if (out_smoothed_height !== want.mean)
          note_mismatch($sformatf("mean exp %h got %h", want.mean, out_smoothed_height));
        if (out_window_count !== want.cnt)
          note_mismatch($sformatf("count exp %0d got %0d", want.cnt, out_window_count));
        if (out_frame_last !== want.last)
          note_mismatch($sformatf("last exp %b got %b", want.last, out_frame_last));
      end
    end
  end

  initial begin
    bit        has;
    mean_res_t r;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    in_cmd = CMD_SAMPLE;
    in_height_sample = '0;
    out_ready = 1'b0;
    mismatches = 0;
    items_sent = 0;
    idle_off = 1'b0;
    hold_req = 1'b0;
    row_width = 1024;
    row_count = 1024;
    restart_frame();
    for (int i = 0; i < 1024; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // a few samples under the reset geometry
    for (int i = 0; i < 3; i++) send_item(CMD_SAMPLE, 8'($urandom), has, r);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        settle();
        write_reg(directed_rows[k].idx, directed_rows[k].data);
      end else begin
        send_item(directed_rows[k].cmd, directed_rows[k].data[7:0], has, r);
        if (directed_rows[k].chk && (!has || r !== directed_rows[k].res))
          note_mismatch($sformatf("row %0d exp %h got %h", k, directed_rows[k].res, r));
      end
    end
    // last sample of the 3x3 frame, then flush it through drains
    send_item(CMD_SAMPLE, 8'hFF, has, r);
    for (int i = 0; i < 4; i++) send_item(CMD_DRAIN, 8'($urandom), has, r);

    // extremes of both registers
    run_frame(11'h7FF, 1, 1060, 0);
    run_frame(0, 13'h1FFF, 40, 0);
    run_frame(0, 0, 0, 0);

    // long receiver hold-off, then a sender pause mid-frame
    run_frame(12, 3, 0, 1);
    run_frame(6, 4, 0, 2);

    while (items_sent < 1350) begin
      case ($urandom_range(0, 19))
        0: run_frame(0, $urandom_range(0, 3), 0, 0);
        1, 2, 3, 4, 5:
          run_frame($urandom_range(9, 40), $urandom_range(1, 3), 0, 0);
        default:
          run_frame($urandom_range(1, 8), $urandom_range(1, 6), 0, 0);
      endcase
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_means.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
